>>> src/ati_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ati_pkg
// Shared constants, codes, command struct and arctangent table for the
// accelerometer tilt indicator.
// ----------------------------------------------------------------------------
package ati_pkg;

	localparam int ANGLE_FRAC  = 6;
	localparam int ACC_FRAC    = 20;
	localparam int ROT_STEPS   = 16;
	localparam int ROOT_CYCLES = 16;
	localparam int CNT_W       = $clog2(ROT_STEPS > ROOT_CYCLES ? ROT_STEPS : ROOT_CYCLES);
	localparam int ROT_IDX_W   = $clog2(ROT_STEPS);

	localparam int AXIS_W = 16;
	localparam int SQ_W   = 32;
	localparam int ROOT_W = 32;
	localparam int CX_W   = 36;
	localparam int ACC_W  = 29;
	localparam int TBL_W  = 27;
	localparam int ANG_W  = 14;
	localparam int MAG_W  = ANG_W - 1;
	localparam int THR_W  = 13;
	localparam int RND_SH = ACC_FRAC - ANGLE_FRAC;

	localparam logic [MAG_W-1:0] ANG_FULL  = MAG_W'(90 << ANGLE_FRAC);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(192);

	// class / mark codes
	localparam logic [1:0] CL_LEVEL = 2'd0;
	localparam logic [1:0] CL_POS   = 2'd1;
	localparam logic [1:0] CL_NEG   = 2'd2;
	localparam logic [1:0] CL_HOLD  = 2'd3;

	// LED colors: bit 2 red, bit 1 green, bit 0 blue
	localparam logic [2:0] LED_OFF    = 3'd0;
	localparam logic [2:0] LED_GREEN  = 3'd2;
	localparam logic [2:0] LED_RED    = 3'd4;
	localparam logic [2:0] LED_PURPLE = 3'd5;
	localparam logic [2:0] LED_YELLOW = 3'd6;

	typedef struct packed {
		logic                 load_in;
		logic                 load_sq;
		logic                 load_root;
		logic                 root_step;
		logic                 load_rot;
		logic                 rot_step;
		logic [ROT_IDX_W-1:0] rot_idx;
		logic                 load_ang;
		logic                 write_out;
	} ati_cmd_t;

	// atan(2^-i) in degrees, Q20
	function automatic logic [TBL_W-1:0] atan_q20(input logic [4:0] i);
		logic [TBL_W-1:0] v;
		begin
			unique case (i)
				5'd0:    v = TBL_W'(47185920);
				5'd1:    v = TBL_W'(27855475);
				5'd2:    v = TBL_W'(14718068);
				5'd3:    v = TBL_W'(7471121);
				5'd4:    v = TBL_W'(3750058);
				5'd5:    v = TBL_W'(1876857);
				5'd6:    v = TBL_W'(938658);
				5'd7:    v = TBL_W'(469357);
				5'd8:    v = TBL_W'(234682);
				5'd9:    v = TBL_W'(117342);
				5'd10:   v = TBL_W'(58671);
				5'd11:   v = TBL_W'(29335);
				5'd12:   v = TBL_W'(14668);
				5'd13:   v = TBL_W'(7334);
				5'd14:   v = TBL_W'(3667);
				5'd15:   v = TBL_W'(1833);
				5'd16:   v = TBL_W'(917);
				5'd17:   v = TBL_W'(458);
				5'd18:   v = TBL_W'(229);
				5'd19:   v = TBL_W'(115);
				5'd20:   v = TBL_W'(57);
				5'd21:   v = TBL_W'(29);
				5'd22:   v = TBL_W'(14);
				5'd23:   v = TBL_W'(7);
				default: v = '0;
			endcase
			return v;
		end
	endfunction

endpackage
`default_nettype wire

>>> src/ati_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ati_isqrt
// Integer square root of (sq * 2^32), restoring digit recurrence, two
// result bits per cycle while step is high.
// ----------------------------------------------------------------------------
module ati_isqrt (
	input  wire logic                      clk,
	input  wire logic                      load,
	input  wire logic                      step,
	input  wire logic [ati_pkg::SQ_W-1:0]  sq,
	output logic      [ati_pkg::ROOT_W-1:0] root
);

	localparam int REM_W = ati_pkg::ROOT_W + 4;

	typedef struct packed {
		logic [REM_W-1:0]         rem;
		logic [ati_pkg::ROOT_W-1:0] root;
	} sqrt_st_t;

	logic [ati_pkg::SQ_W-1:0]   src_q;
	logic [REM_W-1:0]           rem_q;
	logic [ati_pkg::ROOT_W-1:0] root_q;
	sqrt_st_t                   st0, st1, st2;

	function automatic sqrt_st_t digit(input sqrt_st_t s, input logic [1:0] pair);
		logic [REM_W-1:0] sh;
		logic [REM_W-1:0] trial;
		sqrt_st_t         r;
		begin
			sh    = {s.rem[REM_W-3:0], pair};
			trial = {2'b00, s.root, 2'b01};
			if (sh >= trial) begin
				r.rem  = sh - trial;
				r.root = {s.root[ati_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				r.rem  = sh;
				r.root = {s.root[ati_pkg::ROOT_W-2:0], 1'b0};
			end
			return r;
		end
	endfunction

	always_comb begin
		st0.rem  = rem_q;
		st0.root = root_q;
		st1      = digit(st0, src_q[ati_pkg::SQ_W-1 -: 2]);
		st2      = digit(st1, src_q[ati_pkg::SQ_W-3 -: 2]);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			src_q  <= sq;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			src_q  <= {src_q[ati_pkg::SQ_W-5:0], 4'b0000};
			rem_q  <= st2.rem;
			root_q <= st2.root;
		end
	end

	assign root = root_q;

endmodule
`default_nettype wire

>>> src/ati_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ati_cordic
// Vectoring rotation unit: drives y toward zero, one iteration per cycle
// while step is high, accumulating the angle in degrees (Q20).
// ----------------------------------------------------------------------------
module ati_cordic (
	input  wire logic                             clk,
	input  wire logic                             load,
	input  wire logic                             step,
	input  wire logic [ati_pkg::ROT_IDX_W-1:0]    idx,
	input  wire logic [ati_pkg::ROOT_W-1:0]       x0,
	input  wire logic [ati_pkg::ROOT_W-1:0]       y0,
	output logic signed [ati_pkg::ACC_W-1:0]      acc
);

	logic signed [ati_pkg::CX_W-1:0]  x_q, y_q;
	logic signed [ati_pkg::ACC_W-1:0] acc_q;
	logic signed [ati_pkg::CX_W-1:0]  dx, dy;
	logic signed [ati_pkg::ACC_W-1:0] ang;
	logic                             y_pos;

	// arithmetic shift that truncates toward zero
	function automatic logic signed [ati_pkg::CX_W-1:0] shr_trunc(
		input logic signed [ati_pkg::CX_W-1:0]    v,
		input logic        [ati_pkg::ROT_IDX_W-1:0] s
	);
		logic signed [ati_pkg::CX_W-1:0] bias;
		begin
			bias = v[ati_pkg::CX_W-1] ? signed'((ati_pkg::CX_W'(1) << s) - ati_pkg::CX_W'(1))
			                          : '0;
			return (v + bias) >>> s;
		end
	endfunction

	always_comb begin
		dx    = shr_trunc(y_q, idx);
		dy    = shr_trunc(x_q, idx);
		ang   = signed'(ati_pkg::ACC_W'(ati_pkg::atan_q20(5'(idx))));
		y_pos = !y_q[ati_pkg::CX_W-1] && (y_q != '0);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q   <= signed'(ati_pkg::CX_W'(x0));
			y_q   <= signed'(ati_pkg::CX_W'(y0));
			acc_q <= '0;
		end else if (step) begin
			if (y_pos) begin
				x_q   <= x_q + dx;
				y_q   <= y_q - dy;
				acc_q <= acc_q + ang;
			end else begin
				x_q   <= x_q - dx;
				y_q   <= y_q + dy;
				acc_q <= acc_q - ang;
			end
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

>>> src/ati_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ati_dp
// Datapath: axis squares, two root units, two rotation units, angle
// rounding, threshold classification and shown state.
// ----------------------------------------------------------------------------
module ati_dp (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ati_pkg::ati_cmd_t                 cmd,
	input  wire logic signed [ati_pkg::AXIS_W-1:0] accel_x,
	input  wire logic signed [ati_pkg::AXIS_W-1:0] accel_y,
	input  wire logic signed [ati_pkg::AXIS_W-1:0] accel_z,
	input  wire logic                              cfg_wr_en,
	input  wire logic [ati_pkg::THR_W-1:0]         cfg_wr_data,
	output logic signed [ati_pkg::ANG_W-1:0]       pitch_angle,
	output logic signed [ati_pkg::ANG_W-1:0]       roll_angle,
	output logic [1:0]                             roll_mark,
	output logic [1:0]                             pitch_mark,
	output logic                                   led_red,
	output logic                                   led_green,
	output logic                                   led_blue
);

	localparam int PROD_W = 2 * ati_pkg::AXIS_W;

	logic signed [ati_pkg::AXIS_W-1:0] x_q, y_q, z_q;
	logic                              zero_q;
	logic [ati_pkg::SQ_W-1:0]          xx_q, yy_q, zz_q;
	logic [ati_pkg::SQ_W-1:0]          sq_p, sq_r;
	logic                              p_sq0_q, r_sq0_q;
	logic [ati_pkg::AXIS_W-1:0]        mag_x, mag_y;
	logic [ati_pkg::ROOT_W-1:0]        root_p, root_r;
	logic signed [ati_pkg::ACC_W-1:0]  acc_p, acc_r;
	logic signed [ati_pkg::ANG_W-1:0]  ang_p, ang_r;
	logic signed [ati_pkg::ANG_W-1:0]  pitch_ang_q, roll_ang_q;
	logic signed [ati_pkg::ANG_W-1:0]  pitch_out_q, roll_out_q;
	logic [ati_pkg::THR_W-1:0]         thr_q;
	logic [1:0]                        roll_shown_q, pitch_shown_q;
	logic [2:0]                        led_q;
	logic [1:0]                        cls_p, cls_r;

	function automatic logic [ati_pkg::AXIS_W-1:0] abs16(
		input logic signed [ati_pkg::AXIS_W-1:0] v
	);
		logic signed [ati_pkg::AXIS_W:0] w;
		begin
			w = {v[ati_pkg::AXIS_W-1], v};
			if (v[ati_pkg::AXIS_W-1])
				w = -w;
			return w[ati_pkg::AXIS_W-1:0];
		end
	endfunction

	// round Q20 accumulator to output LSBs, clamp, apply numerator sign
	function automatic logic signed [ati_pkg::ANG_W-1:0] finish(
		input logic signed [ati_pkg::ACC_W-1:0] a,
		input logic                             num_zero,
		input logic                             den_zero,
		input logic                             neg
	);
		logic [ati_pkg::ACC_W-1:0]   pos;
		logic [ati_pkg::ACC_W-1:0]   rnd;
		logic [ati_pkg::ACC_W-1:0]   sh;
		logic [ati_pkg::MAG_W-1:0]   mag;
		logic signed [ati_pkg::ANG_W-1:0] r;
		begin
			pos = a[ati_pkg::ACC_W-1] ? '0 : ati_pkg::ACC_W'(a);
			rnd = pos + (ati_pkg::ACC_W'(1) << (ati_pkg::RND_SH - 1));
			sh  = rnd >> ati_pkg::RND_SH;
			if (sh > ati_pkg::ACC_W'(ati_pkg::ANG_FULL))
				mag = ati_pkg::ANG_FULL;
			else
				mag = sh[ati_pkg::MAG_W-1:0];
			if (num_zero)
				mag = '0;
			else if (den_zero)
				mag = ati_pkg::ANG_FULL;
			r = signed'({1'b0, mag});
			if (neg)
				r = -r;
			return r;
		end
	endfunction

	function automatic logic [1:0] classify(
		input logic signed [ati_pkg::ANG_W-1:0] a,
		input logic [ati_pkg::THR_W-1:0]        t
	);
		logic signed [ati_pkg::ANG_W:0] aw, tw;
		logic [1:0]                     c;
		begin
			aw = ati_pkg::ANG_W'(a) == '0 ? '0 : {a[ati_pkg::ANG_W-1], a};
			tw = signed'((ati_pkg::ANG_W + 1)'(t));
			if (aw > tw)
				c = ati_pkg::CL_POS;
			else if (aw < -tw)
				c = ati_pkg::CL_NEG;
			else if (aw > -tw && aw < tw)
				c = ati_pkg::CL_LEVEL;
			else
				c = ati_pkg::CL_HOLD;
			return c;
		end
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			x_q    <= accel_x;
			y_q    <= accel_y;
			z_q    <= accel_z;
			zero_q <= (accel_x == '0) && (accel_y == '0) && (accel_z == '0);
		end
		if (cmd.load_sq) begin
			xx_q <= ati_pkg::SQ_W'(PROD_W'(x_q * x_q));
			yy_q <= ati_pkg::SQ_W'(PROD_W'(y_q * y_q));
			zz_q <= ati_pkg::SQ_W'(PROD_W'(z_q * z_q));
		end
		if (cmd.load_root) begin
			p_sq0_q <= (sq_p == '0);
			r_sq0_q <= (sq_r == '0);
		end
		if (cmd.load_ang) begin
			pitch_ang_q <= ang_p;
			roll_ang_q  <= ang_r;
		end
		if (cmd.write_out) begin
			pitch_out_q <= pitch_ang_q;
			roll_out_q  <= roll_ang_q;
		end
	end

	always_comb begin
		sq_p  = yy_q + zz_q;
		sq_r  = xx_q + zz_q;
		mag_x = abs16(x_q);
		mag_y = abs16(y_q);
		ang_p = finish(acc_p, x_q == '0, p_sq0_q, x_q[ati_pkg::AXIS_W-1]);
		ang_r = finish(acc_r, y_q == '0, r_sq0_q, y_q[ati_pkg::AXIS_W-1]);
		cls_p = classify(pitch_ang_q, thr_q);
		cls_r = classify(roll_ang_q, thr_q);
	end

	ati_isqrt u_sqrt_p (
		.clk  (clk),
		.load (cmd.load_root),
		.step (cmd.root_step),
		.sq   (sq_p),
		.root (root_p)
	);

	ati_isqrt u_sqrt_r (
		.clk  (clk),
		.load (cmd.load_root),
		.step (cmd.root_step),
		.sq   (sq_r),
		.root (root_r)
	);

	ati_cordic u_rot_p (
		.clk  (clk),
		.load (cmd.load_rot),
		.step (cmd.rot_step),
		.idx  (cmd.rot_idx),
		.x0   (root_p),
		.y0   ({mag_x, 16'h0000}),
		.acc  (acc_p)
	);

	ati_cordic u_rot_r (
		.clk  (clk),
		.load (cmd.load_rot),
		.step (cmd.rot_step),
		.idx  (cmd.rot_idx),
		.x0   (root_r),
		.y0   ({mag_y, 16'h0000}),
		.acc  (acc_r)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ati_pkg::THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// roll updates first, pitch color overrides
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_shown_q  <= ati_pkg::CL_HOLD;
			pitch_shown_q <= ati_pkg::CL_HOLD;
			led_q         <= ati_pkg::LED_OFF;
		end else if (cmd.write_out && !zero_q) begin
			if (cls_r != ati_pkg::CL_HOLD)
				roll_shown_q <= cls_r;
			if (cls_p != ati_pkg::CL_HOLD)
				pitch_shown_q <= cls_p;
			case (cls_p)
				ati_pkg::CL_POS:   led_q <= ati_pkg::LED_GREEN;
				ati_pkg::CL_NEG:   led_q <= ati_pkg::LED_RED;
				ati_pkg::CL_LEVEL: led_q <= ati_pkg::LED_OFF;
				default: begin
					case (cls_r)
						ati_pkg::CL_POS:   led_q <= ati_pkg::LED_PURPLE;
						ati_pkg::CL_NEG:   led_q <= ati_pkg::LED_YELLOW;
						ati_pkg::CL_LEVEL: led_q <= ati_pkg::LED_OFF;
						default:           led_q <= led_q;
					endcase
				end
			endcase
		end
	end

	assign pitch_angle = pitch_out_q;
	assign roll_angle  = roll_out_q;
	assign roll_mark   = roll_shown_q;
	assign pitch_mark  = pitch_shown_q;
	assign led_red     = led_q[2];
	assign led_green   = led_q[1];
	assign led_blue    = led_q[0];

endmodule
`default_nettype wire

>>> src/ati_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ati_ctrl
// Sequencer: accepts a sample, steps the root and rotation units, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module ati_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  wire logic        out_stall,
	output ati_pkg::ati_cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SQ   = 3'd1;
	localparam logic [2:0] S_SUM  = 3'd2;
	localparam logic [2:0] S_ROOT = 3'd3;
	localparam logic [2:0] S_RLD  = 3'd4;
	localparam logic [2:0] S_ROT  = 3'd5;
	localparam logic [2:0] S_RND  = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	localparam logic [ati_pkg::CNT_W-1:0] ROOT_LAST = ati_pkg::CNT_W'(ati_pkg::ROOT_CYCLES - 1);
	localparam logic [ati_pkg::CNT_W-1:0] ROT_LAST  = ati_pkg::CNT_W'(ati_pkg::ROT_STEPS - 1);

	logic [2:0]                state_q, state_d;
	logic [ati_pkg::CNT_W-1:0] cnt_q;
	logic                      out_valid_q;
	logic                      write;

	assign write = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_SQ;
			S_SQ:   state_d = S_SUM;
			S_SUM:  state_d = S_ROOT;
			S_ROOT: if (cnt_q == ROOT_LAST) state_d = S_RLD;
			S_RLD:  state_d = S_ROT;
			S_ROT:  if (cnt_q == ROT_LAST) state_d = S_RND;
			S_RND:  state_d = S_DONE;
			S_DONE: if (write) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ROOT || state_q == S_ROT)
				cnt_q <= cnt_q + ati_pkg::CNT_W'(1);
			else
				cnt_q <= '0;
			if (write)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		cmd.load_in   = (state_q == S_IDLE) && in_valid;
		cmd.load_sq   = (state_q == S_SQ);
		cmd.load_root = (state_q == S_SUM);
		cmd.root_step = (state_q == S_ROOT);
		cmd.load_rot  = (state_q == S_RLD);
		cmd.rot_step  = (state_q == S_ROT);
		cmd.rot_idx   = cnt_q[ati_pkg::ROT_IDX_W-1:0];
		cmd.load_ang  = (state_q == S_RND);
		cmd.write_out = write;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> src/accel_tilt_indicator.sv
`default_nettype none
// An accepted request runs the square, sum, root, rotation-load, 16-step rotation and rounding
// states before out_valid. in_stall holds off new requests until the result is written.
// The next request is taken while the previous result waits in the output register.
// Reset: async, active low; marks blank, LEDs off, threshold 3 degrees, no result pending.
// ----------------------------------------------------------------------------
// accel_tilt_indicator
// Pitch and roll from a three-axis accelerometer sample, with threshold
// marks and an RGB LED color.
// ----------------------------------------------------------------------------
module accel_tilt_indicator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [ati_pkg::AXIS_W-1:0] accel_x,
	input  wire logic signed [ati_pkg::AXIS_W-1:0] accel_y,
	input  wire logic signed [ati_pkg::AXIS_W-1:0] accel_z,
	input  wire logic                              cfg_wr_en,
	input  wire logic [ati_pkg::THR_W-1:0]         cfg_wr_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [ati_pkg::ANG_W-1:0]       pitch_angle,
	output logic signed [ati_pkg::ANG_W-1:0]       roll_angle,
	output logic [1:0]                             roll_mark,
	output logic [1:0]                             pitch_mark,
	output logic                                   led_red,
	output logic                                   led_green,
	output logic                                   led_blue
);

	ati_pkg::ati_cmd_t cmd;

	ati_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ati_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.pitch_angle (pitch_angle),
		.roll_angle  (roll_angle),
		.roll_mark   (roll_mark),
		.pitch_mark  (pitch_mark),
		.led_red     (led_red),
		.led_green   (led_green),
		.led_blue    (led_blue)
	);

endmodule
`default_nettype wire

>>> bench/tb_accel_tilt_indicator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Regression bench for accel_tilt_indicator. A queue-fed driver offers
// accelerometer samples under varying sender gaps and receiver stalls, while a
// monitor checks every reading against an in-bench CORDIC tilt predictor.
// ----------------------------------------------------------------------------
module tb;

	typedef struct {
		logic signed [ati_pkg::AXIS_W-1:0] x;
		logic signed [ati_pkg::AXIS_W-1:0] y;
		logic signed [ati_pkg::AXIS_W-1:0] z;
	} accel_sample_t;

	typedef struct {
		logic signed [ati_pkg::ANG_W-1:0] pitch;
		logic signed [ati_pkg::ANG_W-1:0] roll;
		logic [1:0]                       roll_mark;
		logic [1:0]                       pitch_mark;
		logic                             red;
		logic                             green;
		logic                             blue;
	} tilt_reading_t;

	localparam int LONG_HOLD = 600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [ati_pkg::AXIS_W-1:0] accel_x = '0;
	logic signed [ati_pkg::AXIS_W-1:0] accel_y = '0;
	logic signed [ati_pkg::AXIS_W-1:0] accel_z = '0;
	logic cfg_wr_en = 1'b0;
	logic [ati_pkg::THR_W-1:0] cfg_wr_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ati_pkg::ANG_W-1:0] pitch_angle;
	logic signed [ati_pkg::ANG_W-1:0] roll_angle;
	logic [1:0] roll_mark;
	logic [1:0] pitch_mark;
	logic led_red;
	logic led_green;
	logic led_blue;

	accel_sample_t pending_samples[$];
	tilt_reading_t expected_readings[$];
	accel_sample_t next_sample;
	tilt_reading_t seen_reading;

	logic req_taken = 1'b0;
	logic rx_hold = 1'b0;
	logic hold_go = 1'b0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int mismatches = 0;
	int readings_seen = 0;

	// predictor state
	logic [ati_pkg::THR_W-1:0] thr_model = ati_pkg::THR_RESET;
	logic [1:0] shown_roll = ati_pkg::CL_HOLD;
	logic [1:0] shown_pitch = ati_pkg::CL_HOLD;
	logic [2:0] shown_led = ati_pkg::LED_OFF;

	// atan(2^-i) in degrees, Q20
	longint atan_tbl [0:23] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	accel_tilt_indicator DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.accel_x     (accel_x),
		.accel_y     (accel_y),
		.accel_z     (accel_z),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pitch_angle (pitch_angle),
		.roll_angle  (roll_angle),
		.roll_mark   (roll_mark),
		.pitch_mark  (pitch_mark),
		.led_red     (led_red),
		.led_green   (led_green),
		.led_blue    (led_blue)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint trunc_shift(input longint v, input int s);
		return (v >= 0) ? (v >>> s) : -((-v) >>> s);
	endfunction

	// atan(num / sqrt(a^2 + b^2)) in 1/64 degree
	function automatic logic signed [ati_pkg::ANG_W-1:0] tilt_deg64(input int num,
			input int a, input int b);
		longint full, xc, yc, acc, dx, dy, res;
		longint unsigned mag, sq, rem, root, bitv;
		int i;
		full = longint'(90) << ati_pkg::ANGLE_FRAC;
		mag = (num < 0) ? longint'(-num) : longint'(num);
		sq = longint'(a) * a + longint'(b) * b;
		if (mag == 0)
			return '0;
		if (sq == 0) begin
			res = full;
		end else begin
			rem = sq << 32;
			root = 0;
			bitv = 64'h1 << 62;
			while (bitv > rem)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (rem >= root + bitv) begin
					rem = rem - (root + bitv);
					root = (root >> 1) + bitv;
				end else begin
					root = root >> 1;
				end
				bitv = bitv >> 2;
			end
			xc = root;
			yc = mag << 16;
			acc = 0;
			for (i = 0; i < ati_pkg::ROT_STEPS && i < 24; i++) begin
				dx = trunc_shift(yc, i);
				dy = trunc_shift(xc, i);
				if (yc > 0) begin
					xc = xc + dx;
					yc = yc - dy;
					acc = acc + atan_tbl[i];
				end else begin
					xc = xc - dx;
					yc = yc + dy;
					acc = acc - atan_tbl[i];
				end
			end
			if (acc < 0)
				acc = 0;
			res = (acc + (longint'(1) << (ati_pkg::ACC_FRAC - 1 - ati_pkg::ANGLE_FRAC)))
				>>> (ati_pkg::ACC_FRAC - ati_pkg::ANGLE_FRAC);
			if (res > full)
				res = full;
		end
		return ati_pkg::ANG_W'((num < 0) ? -res : res);
	endfunction

	function automatic logic [1:0] tilt_class(input logic signed [ati_pkg::ANG_W-1:0] ang);
		int a, t;
		a = ang;
		t = int'(thr_model);
		if (a > t)
			return ati_pkg::CL_POS;
		if (a < -t)
			return ati_pkg::CL_NEG;
		if (a > -t && a < t)
			return ati_pkg::CL_LEVEL;
		return ati_pkg::CL_HOLD;
	endfunction

	function automatic void predict_reading(input int ax, input int ay, input int az);
		tilt_reading_t r;
		logic [1:0] rc, pc;
		r.pitch = '0;
		r.roll = '0;
		if (ax != 0 || ay != 0 || az != 0) begin
			r.pitch = tilt_deg64(ax, ay, az);
			r.roll = tilt_deg64(ay, ax, az);
			rc = tilt_class(r.roll);
			pc = tilt_class(r.pitch);
			if (rc != ati_pkg::CL_HOLD) begin
				shown_roll = rc;
				shown_led = (rc == ati_pkg::CL_POS) ? ati_pkg::LED_PURPLE :
					(rc == ati_pkg::CL_NEG) ? ati_pkg::LED_YELLOW : ati_pkg::LED_OFF;
			end
			if (pc != ati_pkg::CL_HOLD) begin
				shown_pitch = pc;
				shown_led = (pc == ati_pkg::CL_POS) ? ati_pkg::LED_GREEN :
					(pc == ati_pkg::CL_NEG) ? ati_pkg::LED_RED : ati_pkg::LED_OFF;
			end
		end
		r.roll_mark = shown_roll;
		r.pitch_mark = shown_pitch;
		r.red = shown_led[2];
		r.green = shown_led[1];
		r.blue = shown_led[0];
		expected_readings.push_back(r);
	endfunction

	function automatic accel_sample_t mk_sample(input int x, input int y, input int z);
		accel_sample_t s;
		s.x = ati_pkg::AXIS_W'(x);
		s.y = ati_pkg::AXIS_W'(y);
		s.z = ati_pkg::AXIS_W'(z);
		return s;
	endfunction

	function automatic int pick_extreme();
		case ($urandom_range(0, 5))
			0: return -32768;
			1: return -32767;
			2: return -1;
			3: return 0;
			4: return 1;
			default: return 32767;
		endcase
	endfunction

	function automatic int rand_axis();
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic accel_sample_t rand_sample();
		accel_sample_t s;
		int sgn;
		s = mk_sample(rand_axis(), rand_axis(), rand_axis());
		case ($urandom_range(0, 9))
			5: s = mk_sample(int'($urandom_range(0, 16)) - 8, int'($urandom_range(0, 16)) - 8,
				int'($urandom_range(0, 16)) - 8);
			6: begin
				if ($urandom_range(0, 1)) s.x = '0;
				if ($urandom_range(0, 1)) s.y = '0;
				if ($urandom_range(0, 1)) s.z = '0;
			end
			7: s = mk_sample(pick_extreme(), pick_extreme(), pick_extreme());
			8: begin
				// close to level, angles around a few degrees
				sgn = $urandom_range(0, 1) ? 1 : -1;
				s = mk_sample(int'($urandom_range(0, 2400)) - 1200,
					int'($urandom_range(0, 2400)) - 1200,
					sgn * int'($urandom_range(15000, 17500)));
			end
			9: begin
				if ($urandom_range(0, 1))
					s.y = ati_pkg::AXIS_W'(int'($urandom_range(0, 200)) - 100);
				else
					s.z = ati_pkg::AXIS_W'(int'($urandom_range(0, 200)) - 100);
			end
			default: ;
		endcase
		return s;
	endfunction

	task automatic report_mismatch(input string field, input int got, input int want);
		if (mismatches < 200)
			$display("mismatch reading %0d %s: got %0d expected %0d", readings_seen, field, got,
				want);
		mismatches++;
	endtask

	task automatic drain();
		do
			@(posedge clk);
		while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(input int v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= ati_pkg::THR_W'(v);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		thr_model = ati_pkg::THR_W'(v);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || req_taken) begin
			if (pending_samples.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				next_sample = pending_samples.pop_front();
				in_valid <= 1'b1;
				accel_x <= next_sample.x;
				accel_y <= next_sample.y;
				accel_z <= next_sample.z;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall
	always @(negedge clk) begin
		out_stall <= rx_hold || ($urandom_range(0, 99) < rx_stall_pct);
	end

	initial begin
		wait (hold_go);
		@(negedge clk);
		rx_hold <= 1'b1;
		repeat (LONG_HOLD) @(negedge clk);
		rx_hold <= 1'b0;
	end

	// acceptance and checking
	always @(posedge clk) begin
		req_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			predict_reading(accel_x, accel_y, accel_z);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				seen_reading = expected_readings.pop_front();
				if (pitch_angle !== seen_reading.pitch)
					report_mismatch("pitch_angle", pitch_angle, seen_reading.pitch);
				if (roll_angle !== seen_reading.roll)
					report_mismatch("roll_angle", roll_angle, seen_reading.roll);
				if (roll_mark !== seen_reading.roll_mark)
					report_mismatch("roll_mark", roll_mark, seen_reading.roll_mark);
				if (pitch_mark !== seen_reading.pitch_mark)
					report_mismatch("pitch_mark", pitch_mark, seen_reading.pitch_mark);
				if (led_red !== seen_reading.red)
					report_mismatch("led_red", led_red, seen_reading.red);
				if (led_green !== seen_reading.green)
					report_mismatch("led_green", led_green, seen_reading.green);
				if (led_blue !== seen_reading.blue)
					report_mismatch("led_blue", led_blue, seen_reading.blue);
			end
			readings_seen++;
		end
	end

	initial begin
		#18_000_000;
		$display("accel_tilt_indicator regression: fail");
		$finish;
	end

	initial begin : stimulus
		int thr_plan [0:9];
		accel_sample_t s;
		logic signed [ati_pkg::ANG_W-1:0] ang;
		int k, p, n;
		thr_plan = '{0, 5760, 192, -1, 1, 5759, -1, -1, 2880, -1};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset threshold, hand-picked samples
		pending_samples.push_back(mk_sample(0, 0, 0));
		pending_samples.push_back(mk_sample(0, 0, 16384));
		pending_samples.push_back(mk_sample(16384, 0, 0));
		pending_samples.push_back(mk_sample(-16384, 0, 0));
		pending_samples.push_back(mk_sample(0, 16384, 0));
		pending_samples.push_back(mk_sample(0, -16384, 0));
		pending_samples.push_back(mk_sample(0, 0, 0));
		pending_samples.push_back(mk_sample(32767, 32767, 32767));
		pending_samples.push_back(mk_sample(-32768, -32768, -32768));
		pending_samples.push_back(mk_sample(-32768, 0, 0));
		pending_samples.push_back(mk_sample(32767, -32768, 0));
		pending_samples.push_back(mk_sample(0, 0, -32768));
		pending_samples.push_back(mk_sample(1, 0, 0));
		pending_samples.push_back(mk_sample(-1, 0, 0));
		pending_samples.push_back(mk_sample(0, 1, -1));
		pending_samples.push_back(mk_sample(1, -1, 1));
		pending_samples.push_back(mk_sample(-32768, 32767, -32768));
		pending_samples.push_back(mk_sample(900, -900, 16384));
		pending_samples.push_back(mk_sample(-860, 860, -16384));
		pending_samples.push_back(mk_sample(100, 0, 16384));
		pending_samples.push_back(mk_sample(0, 0, 0));
		drain();

		// threshold set exactly on a pitch angle, then on a roll angle
		for (k = 0; k < 2; k++) begin
			s = mk_sample($urandom_range(1, 32767), $urandom_range(1, 32767), rand_axis());
			ang = (k == 0) ? tilt_deg64(s.x, s.y, s.z) : tilt_deg64(s.y, s.x, s.z);
			write_threshold((ang < 0) ? -ang : ang);
			pending_samples.push_back(mk_sample(0, 0, 100));
			pending_samples.push_back(s);
			pending_samples.push_back(mk_sample(-s.x, s.y, s.z));
			pending_samples.push_back(mk_sample(s.x, -s.y, s.z));
			pending_samples.push_back(mk_sample(-s.x, -s.y, -s.z));
			pending_samples.push_back(s);
			pending_samples.push_back(rand_sample());
			drain();
		end

		for (p = 0; p < 10; p++) begin
			write_threshold((thr_plan[p] < 0) ? int'($urandom_range(2, 5758)) : thr_plan[p]);
			case (p % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
				default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
			endcase
			if (p == 4)
				hold_go = 1'b1;
			for (n = 0; n < 120; n++)
				pending_samples.push_back(rand_sample());
			drain();
		end

		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_readings.size() == 0)
			$display("accel_tilt_indicator regression: pass");
		else
			$display("accel_tilt_indicator regression: fail");
		$finish;
	end

endmodule

>>> accel_tilt_indicator.f
src/ati_pkg.sv
src/ati_isqrt.sv
src/ati_cordic.sv
src/ati_dp.sv
src/ati_ctrl.sv
src/accel_tilt_indicator.sv
bench/tb_accel_tilt_indicator.sv
